@@ sv/imrs_pkg.sv @@
// Shared types and constants of the input movie replay sequencer.
`default_nettype none

package imrs_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 4096;
	localparam int unsigned BUTTON_BITS_DEF = 16;

	localparam int ACTION_W    = 3;
	localparam int SLOT_W      = 12;
	localparam int BTN_W       = 16;
	localparam int FRAMES_W    = 32;
	localparam int COUNT_W     = 13;
	localparam int FRAME_NUM_W = 32;
	localparam int PERIOD_W    = 36;
	localparam int PHASE_W     = 37;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 36;

	localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_START = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_PAUSE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_RESET = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FRAME  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 2'd2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 36'd1092266667;
	localparam logic [PHASE_W-1:0]  ONE_US_Q16   = 37'd65536;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [SLOT_W-1:0]   entry_slot;
		logic [BTN_W-1:0]    entry_buttons;
		logic [FRAMES_W-1:0] entry_frames;
	} cmd_t;

	typedef struct packed {
		logic [BTN_W-1:0]       held_buttons;
		logic                   is_running;
		logic [FRAME_NUM_W-1:0] current_frame;
		logic [COUNT_W-1:0]     current_entry;
		logic [FRAMES_W-1:0]    frames_left;
	} res_t;

endpackage

`default_nettype wire

@@ sv/imrs_cmd_if.sv @@
// Command channel carrying one input beat.
`default_nettype none

interface imrs_cmd_if;
	import imrs_pkg::*;

	logic valid;
	logic ready;
	cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/imrs_res_if.sv @@
// Result channel carrying one output beat.
`default_nettype none

interface imrs_res_if;
	import imrs_pkg::*;

	logic valid;
	logic ready;
	res_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/imrs_cfg_if.sv @@
// Configuration write channel.
`default_nettype none

interface imrs_cfg_if;
	import imrs_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source(output valid, output index, output wdata, input ready);
	modport sink(input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

@@ sv/imrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module imrs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ sv/input_movie_replay_sequencer_top.sv @@
// Input movie replay sequencer: run table, frame-phase timing and playback control.
//
// Usage: every beat on cmd carries an action (microsecond tick, start, pause,
// playback reset, table write). Each accepted beat yields exactly one beat on
// res showing button word, running flag, frame number, entry index and frames
// left after the action. Registers are written through cfg (0 entry count,
// 1 first frame number, 2 frame period in 20.16 microseconds); cfg is taken
// only between items and has priority over cmd in the same cycle.
// An accepted cmd passes through an execute state and then a done state that
// loads the output register; each table read of an entry load adds a read state
// and a check state, so a load that skips zero-frame entries repeats that pair for
// each one, while a walk that runs past the last entry ends in a read state. One item is worked
// on at a time; the table RAM read port sets the pace of the skip walk.
// cmd is taken again as soon as the result sits in the output register, so
// a stalled receiver holds at most one finished result while the next item
// is processed; that item then waits until the output register frees.
// arst_n clears playback state and registers to their reset values; table
// contents are undefined until written.
`default_nettype none

module input_movie_replay_sequencer_top #(
	parameter int unsigned TABLE_DEPTH = imrs_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned BUTTON_BITS = imrs_pkg::BUTTON_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	imrs_cmd_if.sink   cmd,
	imrs_res_if.source res,
	imrs_cfg_if.sink   cfg
);
	import imrs_pkg::*;

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned PW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned EW = BUTTON_BITS + FRAMES_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD,
		ST_CHK,
		ST_DONE
	} state_t;

	state_t                 state_q;
	cmd_t                   item_q;
	logic [COUNT_W-1:0]     entry_count_q;
	logic [FRAME_NUM_W-1:0] first_frame_q;
	logic [PERIOD_W-1:0]    period_q;
	logic                   running_q;
	logic [PW-1:0]          ptr_q;
	logic [FRAMES_W-1:0]    rem_q;
	logic [FRAME_NUM_W-1:0] frame_q;
	logic [BUTTON_BITS-1:0] btn_q;
	logic [PHASE_W-1:0]     phase_q;
	logic                   res_valid_q;
	res_t                   res_data_q;

	logic [31:0]            limit32;
	logic [PW-1:0]          limit;
	logic [PW-1:0]          ptr_inc;
	logic [PHASE_W-1:0]     per_now;
	logic [PHASE_W-1:0]     phase_sum;
	logic [31:0]            slot32;
	logic [31:0]            btn_in32;
	logic [31:0]            btn32;
	logic [31:0]            ptr32;
	logic                   ram_we;
	logic [AW-1:0]          ram_waddr;
	logic [EW-1:0]          ram_wdata;
	logic                   ram_re;
	logic [EW-1:0]          ram_rdata;
	logic [FRAMES_W-1:0]    rd_frames;
	logic [BUTTON_BITS-1:0] rd_btn;

	always_comb begin
		limit32 = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
			: 32'(entry_count_q);
		limit   = limit32[PW-1:0];
		ptr_inc = ptr_q + 1'b1;
		per_now = ({1'b0, period_q} < ONE_US_Q16) ? ONE_US_Q16 : {1'b0, period_q};
		phase_sum = phase_q + ONE_US_Q16;
		slot32    = 32'(item_q.entry_slot);
		btn_in32  = 32'(item_q.entry_buttons);
		btn32     = 32'(btn_q);
		ptr32     = 32'(ptr_q);
		rd_frames = ram_rdata[FRAMES_W-1:0];
		rd_btn    = ram_rdata[EW-1:FRAMES_W];
	end

	assign ram_we    = (state_q == ST_EXEC) && (item_q.action == ACT_WRITE)
		&& (slot32 < 32'(TABLE_DEPTH));
	assign ram_waddr = slot32[AW-1:0];
	assign ram_wdata = {btn_in32[BUTTON_BITS-1:0], item_q.entry_frames};
	assign ram_re    = (state_q == ST_RD) && (ptr_q < limit);

	imrs_ram #(
		.WIDTH(EW),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ptr_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign cfg.ready = (state_q == ST_IDLE);
	assign cmd.ready = (state_q == ST_IDLE) && !cfg.valid;
	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			item_q        <= '0;
			entry_count_q <= '0;
			first_frame_q <= '0;
			period_q      <= PERIOD_RESET;
			running_q     <= 1'b0;
			ptr_q         <= '0;
			rem_q         <= '0;
			frame_q       <= '0;
			btn_q         <= '0;
			phase_q       <= '0;
			res_valid_q   <= 1'b0;
			res_data_q    <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ENTRY_COUNT:  entry_count_q <= cfg.wdata[COUNT_W-1:0];
					CFG_FIRST_FRAME:  first_frame_q <= cfg.wdata[FRAME_NUM_W-1:0];
					CFG_FRAME_PERIOD: period_q      <= cfg.wdata[PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (res.valid && res.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.valid && cmd.ready) begin
						item_q  <= cmd.data;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_DONE;
					case (item_q.action)
						ACT_TICK: begin
							if (running_q) begin
								if (phase_sum >= per_now) begin
									phase_q <= phase_sum - per_now;
									if (ptr_q < limit) begin
										if (rem_q != '0) begin
											rem_q   <= rem_q - 32'd1;
											frame_q <= frame_q + 32'd1;
										end
										if (rem_q <= 32'd1) begin
											ptr_q   <= ptr_inc;
											state_q <= ST_RD;
										end
									end
								end else begin
									phase_q <= phase_sum;
								end
							end
						end
						ACT_START: begin
							if (entry_count_q != '0) begin
								running_q <= 1'b1;
								phase_q   <= '0;
							end
						end
						ACT_PAUSE: running_q <= 1'b0;
						ACT_RESET: begin
							running_q <= 1'b0;
							ptr_q     <= '0;
							rem_q     <= '0;
							frame_q   <= first_frame_q;
							btn_q     <= '0;
							phase_q   <= '0;
							state_q   <= ST_RD;
						end
						default: ;
					endcase
				end
				ST_RD: begin
					if (ptr_q < limit) begin
						state_q <= ST_CHK;
					end else begin
						btn_q     <= '0;
						rem_q     <= '0;
						running_q <= 1'b0;
						state_q   <= ST_DONE;
					end
				end
				ST_CHK: begin
					if (rd_frames != '0) begin
						btn_q   <= rd_btn;
						rem_q   <= rd_frames;
						state_q <= ST_DONE;
					end else begin
						ptr_q   <= ptr_inc;
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q                <= 1'b1;
						res_data_q.held_buttons    <= btn32[BTN_W-1:0];
						res_data_q.is_running      <= running_q;
						res_data_q.current_frame   <= frame_q;
						res_data_q.current_entry   <= ptr32[COUNT_W-1:0];
						res_data_q.frames_left     <= rem_q;
						state_q                    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHK |-> ptr_q < limit)
		else $error("table check on entry outside the used range");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ptr_q) <= 32'(TABLE_DEPTH))
		else $error("entry pointer beyond table depth");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!res_valid_q || res.ready)) |=> res.valid)
		else $error("finished item did not reach the output register");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !$past(res.valid)) |-> $past(state_q == ST_DONE))
		else $error("result beat appeared without a finished item");
`endif

endmodule

`default_nettype wire

@@ tb/sv/imrs_playback_checker.sv @@
// Watches the channels of the replay sequencer, predicts each result beat and compares it.
`default_nettype none

module imrs_playback_checker #(
	parameter int unsigned TABLE_DEPTH = imrs_pkg::TABLE_DEPTH_DEF
) (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            cmd_valid,
	input wire logic                            cmd_ready,
	input wire imrs_pkg::cmd_t                  cmd_data,
	input wire logic                            res_valid,
	input wire logic                            res_ready,
	input wire imrs_pkg::res_t                  res_data,
	input wire logic                            cfg_valid,
	input wire logic                            cfg_ready,
	input wire logic [imrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire logic [imrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int unsigned                         mismatch_count,
	output int unsigned                         results_owed
);
	import imrs_pkg::*;

	logic [BTN_W-1:0]       run_buttons [TABLE_DEPTH];
	logic [FRAMES_W-1:0]    run_frames  [TABLE_DEPTH];

	logic [COUNT_W-1:0]     cfg_entry_count;
	logic [FRAME_NUM_W-1:0] cfg_first_frame;
	logic [PERIOD_W-1:0]    cfg_period;

	logic                   playing;
	int unsigned            run_index;
	logic [FRAMES_W-1:0]    frames_to_go;
	logic [FRAME_NUM_W-1:0] frame_no;
	logic [BTN_W-1:0]       shown_buttons;
	logic [PHASE_W-1:0]     frame_phase;

	res_t        expected_status_q [$];
	int unsigned status_index;

	task automatic report_mismatch(input string what);
		if (mismatch_count < 200)
			$display("status beat %0d: %s", status_index, what);
		mismatch_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
	endtask

	function automatic int unsigned entries_in_use();
		return (cfg_entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(cfg_entry_count);
	endfunction

	task automatic load_next_run();
		int unsigned last;
		last = entries_in_use();
		while (run_index < last) begin
			shown_buttons = run_buttons[run_index];
			frames_to_go  = run_frames[run_index];
			if (frames_to_go != '0)
				return;
			run_index++;
		end
		shown_buttons = '0;
		frames_to_go  = '0;
		playing       = 1'b0;
	endtask

	task automatic advance_frame();
		if (!playing || run_index >= entries_in_use())
			return;
		if (frames_to_go != '0) begin
			frames_to_go--;
			frame_no++;
		end
		if (frames_to_go == '0) begin
			run_index++;
			load_next_run();
		end
	endtask

	task automatic predict_status(input cmd_t c, output res_t r);
		logic [PHASE_W-1:0] period_eff;
		case (c.action)
			ACT_TICK: begin
				if (playing) begin
					period_eff = {1'b0, cfg_period};
					if (period_eff < ONE_US_Q16)
						period_eff = ONE_US_Q16;
					frame_phase = frame_phase + ONE_US_Q16;
					if (frame_phase >= period_eff) begin
						advance_frame();
						frame_phase = frame_phase - period_eff;
					end
				end
			end
			ACT_START: begin
				if (cfg_entry_count != '0) begin
					playing     = 1'b1;
					frame_phase = '0;
				end
			end
			ACT_PAUSE: playing = 1'b0;
			ACT_RESET: begin
				playing       = 1'b0;
				run_index     = 0;
				frames_to_go  = '0;
				frame_no      = cfg_first_frame;
				shown_buttons = '0;
				frame_phase   = '0;
				load_next_run();
			end
			ACT_WRITE: begin
				if (c.entry_slot < TABLE_DEPTH) begin
					run_buttons[c.entry_slot] = c.entry_buttons;
					run_frames[c.entry_slot]  = c.entry_frames;
				end
			end
			default: ;
		endcase
		r.held_buttons  = shown_buttons;
		r.is_running    = playing;
		r.current_frame = frame_no;
		r.current_entry = COUNT_W'(run_index);
		r.frames_left   = frames_to_go;
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t next_status;
		if (!arst_n) begin
			cfg_entry_count = '0;
			cfg_first_frame = '0;
			cfg_period      = PERIOD_RESET;
			playing         = 1'b0;
			run_index       = 0;
			frames_to_go    = '0;
			frame_no        = '0;
			shown_buttons   = '0;
			frame_phase     = '0;
			status_index    = 0;
			mismatch_count  = 0;
			expected_status_q.delete();
		end else begin
			if (res_valid && res_ready) begin
				if (expected_status_q.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = expected_status_q.pop_front();
					check_field("held_buttons", 32'(res_data.held_buttons),
						32'(want.held_buttons));
					check_field("is_running", 32'(res_data.is_running), 32'(want.is_running));
					check_field("current_frame", res_data.current_frame, want.current_frame);
					check_field("current_entry", 32'(res_data.current_entry),
						32'(want.current_entry));
					check_field("frames_left", res_data.frames_left, want.frames_left);
				end
				status_index++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ENTRY_COUNT:  cfg_entry_count = cfg_wdata[COUNT_W-1:0];
					CFG_FIRST_FRAME:  cfg_first_frame = cfg_wdata[FRAME_NUM_W-1:0];
					CFG_FRAME_PERIOD: cfg_period      = cfg_wdata[PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (cmd_valid && cmd_ready) begin
				predict_status(cmd_data, next_status);
				expected_status_q.push_back(next_status);
			end
		end
		results_owed = expected_status_q.size();
	end

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Top of the replay sequencer testbench: clock, reset, stimulus, stalls and verdict.
`default_nettype none

module testbench;
	import imrs_pkg::*;

	localparam int unsigned TABLE_SLOTS  = 64;
	localparam int unsigned CYCLE_LIMIT  = 4_000_000;
	localparam int unsigned DRAIN_CYCLES = 40;

	localparam logic [ACTION_W-1:0] ACT_SPARE_FIRST = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_SPARE_LAST  = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        cmd_taken;
	logic        cfg_taken;
	bit          quiet;
	bit          written_slot [TABLE_SLOTS];
	int unsigned cycle_count = 0;
	int unsigned ready_hold = 0;
	int unsigned mismatch_count;
	int unsigned results_owed;

	imrs_cmd_if cmd_ch ();
	imrs_res_if res_ch ();
	imrs_cfg_if cfg_ch ();

	input_movie_replay_sequencer_top #(
		.TABLE_DEPTH (TABLE_SLOTS)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	imrs_playback_checker #(
		.TABLE_DEPTH (TABLE_SLOTS)
	) i_playback_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_ch.valid),
		.cmd_ready      (cmd_ch.ready),
		.cmd_data       (cmd_ch.data),
		.res_valid      (res_ch.valid),
		.res_ready      (res_ch.ready),
		.res_data       (res_ch.data),
		.cfg_valid      (cfg_ch.valid),
		.cfg_ready      (cfg_ch.ready),
		.cfg_index      (cfg_ch.index),
		.cfg_wdata      (cfg_ch.wdata),
		.mismatch_count (mismatch_count),
		.results_owed   (results_owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cmd_taken <= cmd_ch.valid && cmd_ch.ready;
		cfg_taken <= cfg_ch.valid && cfg_ch.ready;
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int unsigned idle_gap();
		int unsigned pick;
		if (quiet)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 88)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(negedge clk) begin
		int unsigned gap;
		if (ready_hold != 0) begin
			res_ch.ready <= 1'b0;
			ready_hold = ready_hold - 1;
		end else begin
			gap = idle_gap();
			if (gap != 0) begin
				res_ch.ready <= 1'b0;
				ready_hold = gap - 1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	function automatic logic [FRAMES_W-1:0] random_run_length();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 25)
			return '0;
		if (pick < 75)
			return FRAMES_W'($urandom_range(1, 5));
		if (pick < 90)
			return FRAMES_W'($urandom_range(6, 40));
		if (pick < 96)
			return FRAMES_W'($urandom);
		return '1;
	endfunction

	function automatic cmd_t random_payload();
		cmd_t c;
		c.action        = ACT_TICK;
		c.entry_slot    = SLOT_W'($urandom);
		c.entry_buttons = BTN_W'($urandom);
		c.entry_frames  = FRAMES_W'($urandom);
		return c;
	endfunction

	task automatic send(input cmd_t c);
		int unsigned gap;
		gap = idle_gap();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		if (c.action == ACT_WRITE && c.entry_slot < TABLE_SLOTS)
			written_slot[c.entry_slot] = 1'b1;
		do @(negedge clk); while (cmd_taken !== 1'b1);
	endtask

	task automatic send_action(input logic [ACTION_W-1:0] act);
		cmd_t c;
		c = random_payload();
		c.action = act;
		send(c);
	endtask

	task automatic write_run(input logic [SLOT_W-1:0] slot, input logic [BTN_W-1:0] buttons,
		input logic [FRAMES_W-1:0] frames);
		cmd_t c;
		c = random_payload();
		c.action        = ACT_WRITE;
		c.entry_slot    = slot;
		c.entry_buttons = buttons;
		c.entry_frames  = frames;
		send(c);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= data;
		do @(negedge clk); while (cfg_taken !== 1'b1);
	endtask

	// fill every slot in use so that no entry load reads an unwritten slot
	task automatic configure(input int unsigned count, input logic [FRAME_NUM_W-1:0] first,
		input logic [PERIOD_W-1:0] period);
		int unsigned last;
		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
		write_register(CFG_ENTRY_COUNT, CFG_DATA_W'(count));
		write_register(CFG_FIRST_FRAME, CFG_DATA_W'(first));
		write_register(CFG_FRAME_PERIOD, CFG_DATA_W'(period));
		cfg_ch.valid <= 1'b0;
		last = (count > TABLE_SLOTS) ? TABLE_SLOTS : count;
		for (int unsigned s = 0; s < last; s++)
			if (!written_slot[s])
				write_run(SLOT_W'(s), BTN_W'($urandom), random_run_length());
	endtask

	task automatic run_phase(input int unsigned count, input logic [FRAME_NUM_W-1:0] first,
		input logic [PERIOD_W-1:0] period, input int unsigned items);
		cmd_t        c;
		int unsigned pick;
		int unsigned used;
		configure(count, first, period);
		send_action(ACT_RESET);
		send_action(ACT_START);
		used = (count > TABLE_SLOTS) ? TABLE_SLOTS : count;
		for (int unsigned i = 0; i < items; i++) begin
			if ($urandom_range(0, 199) == 0)
				quiet = !quiet;
			c = random_payload();
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				c.action = ACT_TICK;
			end else if (pick < 76) begin
				c.action = ACT_WRITE;
				c.entry_frames = random_run_length();
				if (used != 0 && $urandom_range(0, 3) != 0)
					c.entry_slot = SLOT_W'($urandom_range(0, used - 1));
			end else if (pick < 83) begin
				c.action = ACT_START;
			end else if (pick < 87) begin
				c.action = ACT_PAUSE;
			end else if (pick < 94) begin
				c.action = ACT_RESET;
			end else begin
				c.action = ACTION_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
			end
			send(c);
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		quiet        = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.data  = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.wdata = '0;
		res_ch.ready = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// empty table: start refused, ticks and reset while stopped, spare codes
		send_action(ACT_START);
		send_action(ACT_TICK);
		send_action(ACT_PAUSE);
		send_action(ACT_RESET);
		send_action(ACT_SPARE_FIRST);
		send_action(ACT_SPARE_FIRST + 3'd1);
		send_action(ACT_SPARE_LAST);
		write_run(SLOT_W'(0), '1, FRAMES_W'(2));
		write_run(SLOT_W'(1), BTN_W'(16'h1234), '0);
		write_run(SLOT_W'(2), '0, FRAMES_W'(1));
		write_run('1, '1, '1);

		// frame number wrap, zero-frame skip, stop past the end, start past the end
		configure(3, 32'hFFFF_FFFE, PERIOD_W'(65536));
		send_action(ACT_RESET);
		send_action(ACT_START);
		send_action(ACT_TICK);
		send_action(ACT_TICK);
		send_action(ACT_TICK);
		send_action(ACT_START);
		send_action(ACT_TICK);
		send_action(ACT_PAUSE);

		run_phase(1, 32'd0, PERIOD_W'(65536), 150);
		run_phase(5, FRAME_NUM_W'($urandom), PERIOD_W'(98304), 300);
		run_phase(12, 32'hFFFF_FFFF, '0, 250);
		run_phase(0, 32'd77, PERIOD_W'(131072), 80);
		run_phase(4096, FRAME_NUM_W'($urandom), PERIOD_W'(65536), 300);
		run_phase(8191, 32'd0, PERIOD_W'(200000), 150);
		run_phase(7, FRAME_NUM_W'($urandom), '1, 100);
		run_phase(16, FRAME_NUM_W'($urandom), PERIOD_RESET, 100);
		run_phase(9, FRAME_NUM_W'($urandom), PERIOD_W'(163840), 350);
		run_phase(3, 32'd0, PERIOD_W'(65537), 250);

		cmd_ch.valid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
